>>> hw/rtl/lmbo_pkg.sv
// ----------------------------------------------------------------------------
// lmbo_pkg
// Shared types and constants for the lazy matrix bank owner tracker.
// ----------------------------------------------------------------------------
package lmbo_pkg;

	// default sizes
	localparam int NUM_BANKS_DEF    = 8;
	localparam int NUM_CONTEXTS_DEF = 16;

	// fixed field widths
	localparam int ACTION_W = 2;
	localparam int CTX_W    = 4;
	localparam int SET_W    = 8;
	localparam int CMD_W    = 2;
	localparam int BANK_W   = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INIT   = 2'd0,
		ACT_USE    = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAVE = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_DONE = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CALC,
		ST_WALK,
		ST_OWNRD,
		ST_SAVE,
		ST_LOADCHK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic     latch;      // capture input item
		logic     rd_ctx;     // read mask memory at requester
		logic     rd_owner;   // read mask memory at current bank owner
		logic     wr_init;    // clear requester masks
		logic     wr_calc;    // write requester's updated masks
		logic     wr_clr;     // drop current bank from owner masks
		logic     calc;       // load claim and load sets, restart walk
		logic     free_ctx;   // release table entries naming requester
		logic     take_bank;  // update owner entry of current bank
		logic     step;       // advance bank index
		logic     emit;       // load output register
		command_t emit_kind;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t action;
		logic    ctx_ok;
		logic    no_ctx;
		logic    idx_end;
		logic    claim_bit;
		logic    owner_hit;
		logic    save_bit;
		logic    load_bit;
		logic    out_free;
	} dp_status_t;

endpackage

>>> hw/rtl/lmbo_ctrl.sv
// ----------------------------------------------------------------------------
// lmbo_ctrl
// Sequencer: decodes each item and steps the datapath through the bank walk.
// ----------------------------------------------------------------------------
module lmbo_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lmbo_pkg::dp_status_t sts,
	output lmbo_pkg::dp_cmd_t    cmd
);

	lmbo_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmbo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != lmbo_pkg::ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_kind = lmbo_pkg::CMD_DONE;
		case (state_q)
			lmbo_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = lmbo_pkg::ST_DISPATCH;
				end
			end
			lmbo_pkg::ST_DISPATCH: begin
				state_d = lmbo_pkg::ST_DONE;
				case (sts.action)
					lmbo_pkg::ACT_INIT: begin
						if (sts.ctx_ok) begin
							cmd.wr_init  = 1'b1;
							cmd.free_ctx = 1'b1;
						end
					end
					lmbo_pkg::ACT_DELETE: begin
						if (!sts.no_ctx && sts.ctx_ok) begin
							cmd.free_ctx = 1'b1;
						end
					end
					lmbo_pkg::ACT_USE: begin
						if (sts.no_ctx) begin
							state_d = lmbo_pkg::ST_CALC;
						end else if (sts.ctx_ok) begin
							cmd.rd_ctx = 1'b1;
							state_d    = lmbo_pkg::ST_CALC;
						end
					end
					default: begin
						state_d = lmbo_pkg::ST_DONE;
					end
				endcase
			end
			lmbo_pkg::ST_CALC: begin
				cmd.calc    = 1'b1;
				cmd.wr_calc = !sts.no_ctx;
				state_d     = lmbo_pkg::ST_WALK;
			end
			lmbo_pkg::ST_WALK: begin
				if (sts.idx_end) begin
					state_d = lmbo_pkg::ST_DONE;
				end else if (!sts.claim_bit) begin
					cmd.step = 1'b1;
				end else if (sts.owner_hit) begin
					cmd.rd_owner = 1'b1;
					state_d      = lmbo_pkg::ST_OWNRD;
				end else begin
					state_d = lmbo_pkg::ST_LOADCHK;
				end
			end
			lmbo_pkg::ST_OWNRD: begin
				cmd.wr_clr = 1'b1;
				state_d    = sts.save_bit ? lmbo_pkg::ST_SAVE : lmbo_pkg::ST_LOADCHK;
			end
			lmbo_pkg::ST_SAVE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = lmbo_pkg::CMD_SAVE;
					state_d       = lmbo_pkg::ST_LOADCHK;
				end
			end
			lmbo_pkg::ST_LOADCHK: begin
				if (!sts.load_bit) begin
					cmd.take_bank = 1'b1;
					cmd.step      = 1'b1;
					state_d       = lmbo_pkg::ST_WALK;
				end else if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = lmbo_pkg::CMD_LOAD;
					cmd.take_bank = 1'b1;
					cmd.step      = 1'b1;
					state_d       = lmbo_pkg::ST_WALK;
				end
			end
			lmbo_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = lmbo_pkg::CMD_DONE;
					state_d       = lmbo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lmbo_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/lmbo_dpath.sv
// ----------------------------------------------------------------------------
// lmbo_dpath
// Item capture, per-context mask memory, bank owner table and result register.
// ----------------------------------------------------------------------------
module lmbo_dpath #(
	parameter int NUM_BANKS    = lmbo_pkg::NUM_BANKS_DEF,
	parameter int NUM_CONTEXTS = lmbo_pkg::NUM_CONTEXTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmbo_pkg::dp_cmd_t             cmd,
	output lmbo_pkg::dp_status_t          sts,
	input  logic [lmbo_pkg::ACTION_W-1:0] action,
	input  logic [lmbo_pkg::CTX_W-1:0]    context_id,
	input  logic                          no_context,
	input  logic [lmbo_pkg::SET_W-1:0]    keep_set,
	input  logic [lmbo_pkg::SET_W-1:0]    temp_set,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lmbo_pkg::CMD_W-1:0]    command,
	output logic [lmbo_pkg::BANK_W-1:0]   bank,
	output logic [lmbo_pkg::CTX_W-1:0]    owner,
	output logic                          last
);

	localparam int CTX_AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int BSEL_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int BIDX_W = $clog2(NUM_BANKS + 1);
	localparam int WORD_W = 2 * NUM_BANKS;

	// captured item
	logic [lmbo_pkg::ACTION_W-1:0] act_q;
	logic [lmbo_pkg::CTX_W-1:0]    ctx_q;
	logic                          noctx_q;
	logic [lmbo_pkg::SET_W-1:0]    keep_q;
	logic [lmbo_pkg::SET_W-1:0]    temp_q;

	// walk state
	logic [NUM_BANKS-1:0] claim_q;
	logic [NUM_BANKS-1:0] load_q;
	logic [BIDX_W-1:0]    idx_q;

	// bank owner table
	logic [NUM_BANKS-1:0]       present_q;
	logic [lmbo_pkg::CTX_W-1:0] owner_id_q [NUM_BANKS];

	// mask memory: {owned, valid} per context
	logic [WORD_W-1:0]       mem_q [NUM_CONTEXTS];
	logic [NUM_CONTEXTS-1:0] ent_vld_q;
	logic [WORD_W-1:0]       rd_word_q;

	// result register
	logic                        out_valid_q;
	lmbo_pkg::command_t          command_q;
	logic [lmbo_pkg::BANK_W-1:0] bank_q;
	logic [lmbo_pkg::CTX_W-1:0]  owner_q;
	logic                        last_q;

	logic [BSEL_W-1:0]          bsel;
	logic [NUM_BANKS-1:0]       bit_m;
	logic [lmbo_pkg::CTX_W-1:0] cur_owner;
	logic [CTX_AW-1:0]          ctx_addr;
	logic [CTX_AW-1:0]          own_addr;
	logic [NUM_BANKS-1:0]       rd_owned;
	logic [NUM_BANKS-1:0]       rd_valid;
	logic [NUM_BANKS-1:0]       own_sel;
	logic [NUM_BANKS-1:0]       keep_m;
	logic [NUM_BANKS-1:0]       temp_m;
	logic [NUM_BANKS-1:0]       keep_e;
	logic [NUM_BANKS-1:0]       temp_e;
	logic [NUM_BANKS-1:0]       claim_n;
	logic [NUM_BANKS-1:0]       load_n;
	logic                       out_free;
	logic                       rd_en;
	logic [CTX_AW-1:0]          rd_addr;
	logic                       wr_en;
	logic [CTX_AW-1:0]          wr_addr;
	logic [WORD_W-1:0]          wr_data;

	assign bsel      = idx_q[BSEL_W-1:0];
	assign bit_m     = NUM_BANKS'(1'b1) << bsel;
	assign cur_owner = owner_id_q[bsel];
	assign ctx_addr  = CTX_AW'(ctx_q);
	assign own_addr  = CTX_AW'(cur_owner);
	assign rd_owned  = rd_word_q[WORD_W-1:NUM_BANKS];
	assign rd_valid  = rd_word_q[NUM_BANKS-1:0];
	assign out_free  = !out_valid_q || !out_stall;

	// claim / load sets; without a context nothing is owned and nothing loads
	always_comb begin
		own_sel = noctx_q ? '0 : rd_owned;
		keep_m  = NUM_BANKS'(keep_q);
		temp_m  = NUM_BANKS'(temp_q) & ~keep_m;
		keep_e  = keep_m & ~own_sel;
		temp_e  = temp_m & ~own_sel;
		claim_n = keep_e | temp_e;
		load_n  = noctx_q ? '0 : (keep_e & rd_valid);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q   <= action;
			ctx_q   <= context_id;
			noctx_q <= no_context;
			keep_q  <= keep_set;
			temp_q  <= temp_set;
		end
		if (cmd.calc) begin
			claim_q <= claim_n;
			load_q  <= load_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.calc) begin
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + BIDX_W'(1);
		end
	end

	// owner table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else begin
			if (cmd.free_ctx) begin
				for (int b = 0; b < NUM_BANKS; b++) begin
					if (present_q[b] && owner_id_q[b] == ctx_q) begin
						present_q[b] <= 1'b0;
					end
				end
			end
			if (cmd.take_bank) begin
				present_q[bsel] <= !noctx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_bank) begin
			owner_id_q[bsel] <= ctx_q;
		end
	end

	// mask memory ports
	always_comb begin
		rd_en   = cmd.rd_ctx || cmd.rd_owner;
		rd_addr = cmd.rd_owner ? own_addr : ctx_addr;
		wr_en   = cmd.wr_init || cmd.wr_calc || cmd.wr_clr;
		wr_addr = cmd.wr_clr ? own_addr : ctx_addr;
		if (cmd.wr_clr) begin
			wr_data = rd_word_q & ~{bit_m, bit_m};
		end else if (cmd.wr_calc) begin
			wr_data = {rd_owned | claim_n, (rd_valid | keep_e) & ~temp_e};
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= ent_vld_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	// entries never written read as zero masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[wr_addr] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			command_q <= cmd.emit_kind;
			case (cmd.emit_kind)
				lmbo_pkg::CMD_SAVE: begin
					bank_q  <= lmbo_pkg::BANK_W'(idx_q);
					owner_q <= cur_owner;
					last_q  <= 1'b0;
				end
				lmbo_pkg::CMD_LOAD: begin
					bank_q  <= lmbo_pkg::BANK_W'(idx_q);
					owner_q <= ctx_q;
					last_q  <= 1'b0;
				end
				default: begin
					bank_q  <= '0;
					owner_q <= '0;
					last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;
	assign bank      = bank_q;
	assign owner     = owner_q;
	assign last      = last_q;

	always_comb begin
		sts           = '0;
		sts.action    = lmbo_pkg::action_t'(act_q);
		sts.ctx_ok    = int'(ctx_q) < NUM_CONTEXTS;
		sts.no_ctx    = noctx_q;
		sts.idx_end   = (idx_q == BIDX_W'(NUM_BANKS));
		sts.claim_bit = claim_q[bsel];
		sts.owner_hit = present_q[bsel] && (int'(cur_owner) < NUM_CONTEXTS);
		sts.save_bit  = rd_valid[bsel];
		sts.load_bit  = load_q[bsel];
		sts.out_free  = out_free;
	end

endmodule

>>> hw/rtl/lazy_matrix_bank_owner.sv
// ----------------------------------------------------------------------------
// lazy_matrix_bank_owner
// Lazy save/load tracker for a set of shared matrix register banks.
// ----------------------------------------------------------------------------
// Takes one item at a time. Init clears a context's owned and valid masks and
// frees any bank still naming it; delete frees the bank entries of a context;
// use walks the claimed banks in ascending order, giving a save item for a
// previous owner holding a valid copy, then a load item where the requester's
// kept copy is valid, and claims the bank. Every item ends with a done item
// (last = 1). For each claimed bank held by a previous owner, the walk reads
// that owner's mask memory word and writes it back with the bank cleared
// before giving any save or load item. The bank walk goes one bank per step
// over the mask memory. Result stall holds the walk where it stands.
// No clearing pass after reset: per-context masks read as zero until written.
// ----------------------------------------------------------------------------
module lazy_matrix_bank_owner #(
	parameter int NUM_BANKS    = lmbo_pkg::NUM_BANKS_DEF,
	parameter int NUM_CONTEXTS = lmbo_pkg::NUM_CONTEXTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item in
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lmbo_pkg::ACTION_W-1:0] action,
	input  logic [lmbo_pkg::CTX_W-1:0]    context_id,
	input  logic                          no_context,
	input  logic [lmbo_pkg::SET_W-1:0]    keep_set,
	input  logic [lmbo_pkg::SET_W-1:0]    temp_set,
	// item out
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lmbo_pkg::CMD_W-1:0]    command,
	output logic [lmbo_pkg::BANK_W-1:0]   bank,
	output logic [lmbo_pkg::CTX_W-1:0]    owner,
	output logic                          last
);

	lmbo_pkg::dp_cmd_t    dp_cmd;
	lmbo_pkg::dp_status_t dp_sts;

	// sequencer: one item in flight, in_stall high until its done item is queued
	lmbo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// mask memory, owner table and result register
	lmbo_dpath #(
		.NUM_BANKS    (NUM_BANKS),
		.NUM_CONTEXTS (NUM_CONTEXTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.action     (action),
		.context_id (context_id),
		.no_context (no_context),
		.keep_set   (keep_set),
		.temp_set   (temp_set),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.command    (command),
		.bank       (bank),
		.owner      (owner),
		.last       (last)
	);

endmodule

>>> test/lazy_matrix_bank_owner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lazy_matrix_bank_owner_test
// Self-checking bench for the lazy matrix bank owner tracker.
// ----------------------------------------------------------------------------
// Keeps its own copy of the bank owner table and the per-context owned and
// valid masks. Works out the save, load and done items of every accepted input
// item, and checks the result stream in order, one field at a time. A short
// directed run comes first, then random context-switch traffic with and without
// random gaps on both sides. A long output hold-off fills the block up, and drain
// pauses let the block go quiet.
// ----------------------------------------------------------------------------
module lazy_matrix_bank_owner_test;
	import lmbo_pkg::*;

	localparam int NUM_BANKS    = NUM_BANKS_DEF;
	localparam int NUM_CONTEXTS = NUM_CONTEXTS_DEF;

	// action code with no meaning: done item only
	localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

	localparam int IDLE_PCT    = 22;      // gap chance per cycle, both sides
	localparam int HOLD_CYCLES = 160;     // long output hold-off
	localparam int TAIL_CYCLES = 40;      // settle time after the last result
	localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest clean run

	// one result item as the block should give it
	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [BANK_W-1:0] bank_idx;
		logic [CTX_W-1:0]  ctx;
		logic              fin;
	} bank_cmd_t;

	// ------------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------------
	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [ACTION_W-1:0] action;
	logic [CTX_W-1:0]    context_id;
	logic                no_context;
	logic [SET_W-1:0]    keep_set;
	logic [SET_W-1:0]    temp_set;
	logic                out_valid;
	logic                out_stall;
	logic [CMD_W-1:0]    command;
	logic [BANK_W-1:0]   bank;
	logic [CTX_W-1:0]    owner;
	logic                last;

	lazy_matrix_bank_owner #(
		.NUM_BANKS   (NUM_BANKS),
		.NUM_CONTEXTS(NUM_CONTEXTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.context_id(context_id),
		.no_context(no_context),
		.keep_set  (keep_set),
		.temp_set  (temp_set),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.command   (command),
		.bank      (bank),
		.owner     (owner),
		.last      (last)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predicted state of the tracker
	// ------------------------------------------------------------------------
	logic             owner_set [NUM_BANKS];     // bank entry holds an owner
	logic [CTX_W-1:0] owner_ctx [NUM_BANKS];     // owning context of the bank
	logic [SET_W-1:0] ctx_owned [NUM_CONTEXTS];  // banks held by each context
	logic [SET_W-1:0] ctx_valid [NUM_CONTEXTS];  // held banks worth saving

	bank_cmd_t pending_cmds[$];  // results still owed by the block, oldest first

	int  mismatch_count = 0;
	int  cycle_count    = 0;

	// side controls, set by the tests
	logic tx_gaps  = 1'b0;
	logic rx_gaps  = 1'b0;
	int   hold_req = 0;   // bumped by a test to ask for one long hold-off

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int b,
			input logic [CTX_W-1:0] ctx, input logic fin);
		bank_cmd_t e;
		e.cmd      = cmd;
		e.bank_idx = BANK_W'(b);
		e.ctx      = ctx;
		e.fin      = fin;
		pending_cmds.push_back(e);
	endtask

	// drop every bank entry that still names ctx
	task automatic release_banks(input logic [CTX_W-1:0] ctx);
		for (int b = 0; b < NUM_BANKS; b++)
			if (owner_set[b] && owner_ctx[b] == ctx) begin
				owner_set[b] = 1'b0;
				owner_ctx[b] = '0;
			end
	endtask

	task automatic predict_switch(input logic [ACTION_W-1:0] act,
			input logic [CTX_W-1:0] ctx, input logic nc,
			input logic [SET_W-1:0] keep_in, input logic [SET_W-1:0] temp_in);
		logic [SET_W-1:0] keep;
		logic [SET_W-1:0] temp;
		logic [SET_W-1:0] claim;
		logic [SET_W-1:0] load;
		logic [CTX_W-1:0] prev;
		keep = keep_in;
		temp = temp_in & ~keep_in;  // a kept bank is never temporary too
		// every 4-bit context is in range at 16 contexts
		case (act)
			ACT_INIT: begin
				ctx_owned[ctx] = '0;
				ctx_valid[ctx] = '0;
				release_banks(ctx);
			end
			ACT_DELETE: begin
				if (!nc)
					release_banks(ctx);
			end
			ACT_USE: begin
				if (!nc) begin
					// banks already held need neither claim nor load
					keep           = keep & ~ctx_owned[ctx];
					temp           = temp & ~ctx_owned[ctx];
					claim          = keep | temp;
					load           = keep & ctx_valid[ctx];
					ctx_owned[ctx] = ctx_owned[ctx] | claim;
					ctx_valid[ctx] = (ctx_valid[ctx] | keep) & ~temp;
				end else begin
					claim = keep | temp;
					load  = '0;
				end
				// ascending walk: save old owner's copy, load ours, take it
				for (int b = 0; b < NUM_BANKS; b++) begin
					if (claim[b]) begin
						if (owner_set[b]) begin
							prev = owner_ctx[b];
							if (ctx_valid[prev][b])
								queue_cmd(CMD_SAVE, b, prev, 1'b0);
							ctx_owned[prev][b] = 1'b0;
							ctx_valid[prev][b] = 1'b0;
						end
						if (load[b])
							queue_cmd(CMD_LOAD, b, ctx, 1'b0);
						owner_set[b] = !nc;
						owner_ctx[b] = nc ? '0 : ctx;
					end
				end
			end
			default: ;  // unknown action: done only
		endcase
		queue_cmd(CMD_DONE, 0, '0, 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// sender: offer one item, hold it until taken, predict on acceptance.
	// Entered and left at a falling edge; valid stays high for a following
	// item unless a gap is drawn.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [ACTION_W-1:0] act,
			input logic [CTX_W-1:0] ctx, input logic nc,
			input logic [SET_W-1:0] keep_in, input logic [SET_W-1:0] temp_in);
		while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		action     = act;
		context_id = ctx;
		no_context = nc;
		keep_set   = keep_in;
		temp_set   = temp_in;
		in_valid   = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_switch(act, ctx, nc, keep_in, temp_in);
		@(negedge clk);
	endtask

	// context-switch traffic: mostly use items among a few busy contexts so
	// banks keep changing hands; some init, delete, no-context and noise
	task automatic send_random_item();
		int               pick;
		logic [ACTION_W-1:0] act;
		logic [CTX_W-1:0] ctx;
		logic             nc;
		logic [SET_W-1:0] keep;
		logic [SET_W-1:0] temp;
		pick = $urandom_range(0, 99);
		if (pick < 7)
			act = ACT_INIT;
		else if (pick < 13)
			act = ACT_DELETE;
		else if (pick < 16)
			act = ACT_UNKNOWN;
		else
			act = ACT_USE;
		if ($urandom_range(0, 3) != 0)
			ctx = CTX_W'($urandom_range(0, 3));
		else
			ctx = CTX_W'($urandom_range(0, NUM_CONTEXTS - 1));
		nc   = ($urandom_range(0, 9) == 0);
		keep = SET_W'($urandom);
		temp = SET_W'($urandom);
		// thin out the sets now and then: fewer banks per switch
		if ($urandom_range(0, 2) == 0)
			keep = keep & SET_W'($urandom);
		if ($urandom_range(0, 2) == 0)
			temp = temp & SET_W'($urandom);
		send_item(act, ctx, nc, keep, temp);
	endtask

	// sender goes quiet so the last item is not offered again
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_cmds.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// receiver: random stall, or a long hold-off counted here
	// ------------------------------------------------------------------------
	int hold_seen = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else
			out_stall = rx_gaps && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got_v, input int exp_v);
		$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)",
			what, got_v, exp_v, cycle_count);
		mismatch_count++;
	endtask

	bank_cmd_t oldest;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cmds.size() == 0)
				report_mismatch("result with nothing owed, command", command, -1);
			else begin
				oldest = pending_cmds.pop_front();
				if (command !== oldest.cmd)
					report_mismatch("command", command, oldest.cmd);
				if (bank !== oldest.bank_idx)
					report_mismatch("bank", bank, oldest.bank_idx);
				if (owner !== oldest.ctx)
					report_mismatch("owner", owner, oldest.ctx);
				if (last !== oldest.fin)
					report_mismatch("last", last, oldest.fin);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// field extremes, each action, and the special cases of init, delete,
	// no-context use, overlapping keep and temp sets, and the unknown action
	task automatic test_directed();
		send_item(ACT_INIT,    4'd0,  1'b0, 8'h00, 8'h00);
		send_item(ACT_INIT,    4'd15, 1'b1, 8'hFF, 8'hFF);  // flag ignored
		send_item(ACT_USE,     4'd0,  1'b0, 8'hFF, 8'h00);  // takes every bank
		send_item(ACT_USE,     4'd0,  1'b0, 8'hFF, 8'hFF);  // all held already
		send_item(ACT_USE,     4'd15, 1'b0, 8'h0F, 8'hF0);  // saves all of ctx 0
		send_item(ACT_USE,     4'd0,  1'b0, 8'hFF, 8'hFF);  // temp hidden by keep
		send_item(ACT_USE,     4'd7,  1'b1, 8'h81, 8'h7E);  // no-context claim
		send_item(ACT_USE,     4'd3,  1'b0, 8'hAA, 8'h55);
		send_item(ACT_USE,     4'd5,  1'b0, 8'h55, 8'hAA);
		send_item(ACT_DELETE,  4'd5,  1'b1, 8'h00, 8'h00);  // no-context: nothing
		send_item(ACT_DELETE,  4'd5,  1'b0, 8'h00, 8'h00);  // frees, masks stay
		send_item(ACT_USE,     4'd5,  1'b0, 8'hFF, 8'h00);
		send_item(ACT_USE,     4'd3,  1'b0, 8'h00, 8'h00);  // empty sets
		send_item(ACT_UNKNOWN, 4'd15, 1'b1, 8'hFF, 8'hFF);
		send_item(ACT_UNKNOWN, 4'd0,  1'b0, 8'h00, 8'h00);
		send_item(ACT_USE,     4'd9,  1'b1, 8'h00, 8'hFF);  // temp-only, no context
		send_item(ACT_USE,     4'd3,  1'b0, 8'h00, 8'hFF);
		send_item(ACT_INIT,    4'd3,  1'b0, 8'h00, 8'h00);  // frees banks it held
		send_item(ACT_USE,     4'd15, 1'b0, 8'hFF, 8'h00);
		send_item(ACT_DELETE,  4'd15, 1'b0, 8'hFF, 8'hFF);
		send_item(ACT_USE,     4'd12, 1'b0, 8'hF0, 8'h0F);
		send_item(ACT_USE,     4'd10, 1'b0, 8'h3C, 8'hC3);
		wait_drained();
	endtask

	// long stretches of random traffic; gaps on both sides, then none, then
	// gaps again, with a full drain pause at intervals in the gap stretches
	task automatic test_random_switches();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		for (int i = 0; i < 150; i++) begin
			send_random_item();
			if (i % 50 == 49)
				wait_drained();
		end
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (int i = 0; i < 100; i++)
			send_random_item();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		for (int i = 0; i < 180; i++) begin
			send_random_item();
			if (i % 60 == 59)
				wait_drained();
		end
		wait_drained();
	endtask

	// receiver holds off for a long time while the sender keeps offering,
	// so the block backs up and stalls its input
	task automatic test_output_holdoff();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_req++;
		for (int i = 0; i < 12; i++)
			send_random_item();
		rx_gaps = 1'b1;
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		action     = ACT_INIT;
		context_id = '0;
		no_context = 1'b0;
		keep_set   = '0;
		temp_set   = '0;
		out_stall  = 1'b0;
		for (int b = 0; b < NUM_BANKS; b++) begin
			owner_set[b] = 1'b0;
			owner_ctx[b] = '0;
		end
		for (int c = 0; c < NUM_CONTEXTS; c++) begin
			ctx_owned[c] = '0;
			ctx_valid[c] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_switches();
		test_output_holdoff();

		in_valid = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> lazy_matrix_bank_owner.f
hw/rtl/lmbo_pkg.sv
hw/rtl/lmbo_ctrl.sv
hw/rtl/lmbo_dpath.sv
hw/rtl/lazy_matrix_bank_owner.sv
test/lazy_matrix_bank_owner_test.sv
